// ===== hw/rtl/bfh_pkg.sv =====
`timescale 1ns / 1ps

package bfh_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int OUT_WIDTH   = 32;
  localparam int NUM_VALUES  = 256;
  localparam int BYTE_W      = 8;
  localparam int RANK_W      = 9;
  localparam int REQ_W       = 2;
  localparam int KIND_W      = 2;
  localparam int UNIQ_W      = 9;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_BYTE    = 2'd0,
    REQ_SUMMARY = 2'd1,
    REQ_NEXT    = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_t;

  typedef enum logic [KIND_W-1:0] {
    RES_SUMMARY = 2'd0,
    RES_ENTRY   = 2'd1,
    RES_DONE    = 2'd2
  } res_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_SCAN,
    ST_LAST,
    ST_EMIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0]    result_kind;
    logic [BYTE_W-1:0]    char_code;
    logic [OUT_WIDTH-1:0] char_count;
    logic [OUT_WIDTH-1:0] first_position;
    logic [OUT_WIDTH-1:0] total_chars;
    logic [UNIQ_W-1:0]    unique_chars;
    logic                 is_last;
  } result_t;

  // listing order is signed-char order: rank 0 is byte 0x80
  function automatic logic [BYTE_W-1:0] rank_to_byte(input logic [RANK_W-1:0] rank);
    logic [BYTE_W-1:0] low;
    low = rank[BYTE_W-1:0];
    return {~low[BYTE_W-1], low[BYTE_W-2:0]};
  endfunction

  function automatic logic [OUT_WIDTH-1:0] to_out(input logic [COUNT_WIDTH-1:0] v);
    logic [63:0] ext;
    ext = 64'(v);
    return ext[OUT_WIDTH-1:0];
  endfunction

endpackage

// ===== hw/rtl/bfh_if.sv =====
`timescale 1ns / 1ps

interface bfh_in_if import bfh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [BYTE_W-1:0] byte_value;

  modport source (output valid, output req_type, output byte_value, input ready);
  modport sink (input valid, input req_type, input byte_value, output ready);
endinterface

interface bfh_out_if import bfh_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    result_kind;
  logic [BYTE_W-1:0]    char_code;
  logic [OUT_WIDTH-1:0] char_count;
  logic [OUT_WIDTH-1:0] first_position;
  logic [OUT_WIDTH-1:0] total_chars;
  logic [UNIQ_W-1:0]    unique_chars;
  logic                 is_last;

  modport source (output valid, output result_kind, output char_code, output char_count,
                  output first_position, output total_chars, output unique_chars,
                  output is_last, input ready);
  modport sink (input valid, input result_kind, input char_code, input char_count,
                input first_position, input total_chars, input unique_chars,
                input is_last, output ready);
endinterface

// ===== hw/rtl/byte_frequency_histogram.sv =====
`timescale 1ns / 1ps
// Byte histogram with first-occurrence positions.
// in_chan carries one request per item: a stream byte, a summary (rewinds the
// listing cursor), a next-entry request, or a clear. out_chan returns one
// result for summary and next requests; bytes and clears return nothing.
// Byte items are taken one per cycle back to back while the block is idle:
// per-value counts live in a 256-entry RAM, read when the byte is taken and
// written back the next cycle, with forwarding when consecutive bytes hit
// the same value. Every item is taken only when the block is idle; after a
// summary or next item the input stays not ready until its result has
// entered the output register. Summary: the result is raised in ST_SUM.
// Next: the present map is scanned one rank per cycle from the cursor to the
// entry and on to the following present value (for is_last) in ST_SCAN and
// ST_LAST; the entry then comes from ST_EMIT, or ST_DONE when none is left.
// Reset clears the present map, totals and cursor; the RAM contents need no
// clearing, so the block is ready right after reset.
// A stalled receiver holds the result in the output register; bytes and clears
// are still taken, but a further summary or next item keeps the input not
// ready until the register drains.

module byte_frequency_histogram import bfh_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  bfh_in_if.sink    in_chan,
  bfh_out_if.source out_chan
);

  logic                   cnt_wr_en;
  logic                   pos_wr_en;
  logic [BYTE_W-1:0]      mem_wr_addr;
  logic [COUNT_WIDTH-1:0] cnt_wr_data;
  logic [COUNT_WIDTH-1:0] pos_wr_data;
  logic                   mem_rd_en;
  logic [BYTE_W-1:0]      mem_rd_addr;
  logic [COUNT_WIDTH-1:0] cnt_rd_data;
  logic [COUNT_WIDTH-1:0] pos_rd_data;
  logic                   res_valid;
  logic                   res_ready;
  result_t                res;

  bfh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_VALUES)
  ) u_cnt_ram (
    .clk     (clk),
    .wr_en   (cnt_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (cnt_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (cnt_rd_data)
  );

  bfh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_VALUES)
  ) u_pos_ram (
    .clk     (clk),
    .wr_en   (pos_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (pos_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (pos_rd_data)
  );

  bfh_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .cnt_wr_en   (cnt_wr_en),
    .pos_wr_en   (pos_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .cnt_wr_data (cnt_wr_data),
    .pos_wr_data (pos_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .cnt_rd_data (cnt_rd_data),
    .pos_rd_data (pos_rd_data),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (res_ready)
  );

  bfh_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_chan  (out_chan)
  );

endmodule

// ===== hw/rtl/bfh_ram.sv =====
`timescale 1ns / 1ps

module bfh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/bfh_ctrl.sv =====
`timescale 1ns / 1ps

module bfh_ctrl import bfh_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  bfh_in_if.sink                 in_chan,
  output logic                   cnt_wr_en,
  output logic                   pos_wr_en,
  output logic [BYTE_W-1:0]      mem_wr_addr,
  output logic [COUNT_WIDTH-1:0] cnt_wr_data,
  output logic [COUNT_WIDTH-1:0] pos_wr_data,
  output logic                   mem_rd_en,
  output logic [BYTE_W-1:0]      mem_rd_addr,
  input  logic [COUNT_WIDTH-1:0] cnt_rd_data,
  input  logic [COUNT_WIDTH-1:0] pos_rd_data,
  output logic                   res_valid,
  output result_t                res,
  input  logic                   res_ready
);

  state_t state_r, state_nxt;

  logic [NUM_VALUES-1:0]  present_r, present_nxt;
  logic [COUNT_WIDTH-1:0] total_r, total_nxt;
  logic [UNIQ_W-1:0]      distinct_r, distinct_nxt;
  logic [RANK_W-1:0]      cursor_r, cursor_nxt;

  logic                   s1_vld_r;
  logic [BYTE_W-1:0]      s1_addr_r;
  logic                   fwd_hit_r;
  logic [COUNT_WIDTH-1:0] fwd_val_r;

  logic [RANK_W-1:0]      scan_r;
  logic [RANK_W-1:0]      found_r;
  logic                   last_r;

  req_t                   req;
  logic                   in_acc;
  logic                   byte_acc;
  logic                   s1_present;
  logic [COUNT_WIDTH-1:0] s1_cur;
  logic [COUNT_WIDTH-1:0] s1_cnt;
  logic [BYTE_W-1:0]      scan_byte;
  logic                   scan_end;
  logic                   scan_hit;

  assign req      = req_t'(in_chan.req_type);
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc   = in_chan.valid && (state_r == ST_IDLE);
  assign byte_acc = in_acc && (req == REQ_BYTE);

  // byte update stage: read data arrives here, forwarded when the previous item hit the same entry
  assign s1_present = present_r[s1_addr_r];
  assign s1_cur     = fwd_hit_r ? fwd_val_r : cnt_rd_data;

  always_comb begin
    if (!s1_present) begin
      s1_cnt = COUNT_WIDTH'(1);
    end else if (s1_cur == CNT_MAX) begin
      s1_cnt = s1_cur;
    end else begin
      s1_cnt = s1_cur + 1'b1;
    end
  end

  assign cnt_wr_en   = s1_vld_r;
  assign pos_wr_en   = s1_vld_r && !s1_present;
  assign mem_wr_addr = s1_addr_r;
  assign cnt_wr_data = s1_cnt;
  assign pos_wr_data = total_r;

  assign scan_byte = rank_to_byte(scan_r);
  assign scan_end  = scan_r[RANK_W-1];
  assign scan_hit  = !scan_end && present_r[scan_byte];

  assign mem_rd_en   = byte_acc || ((state_r == ST_SCAN) && scan_hit);
  assign mem_rd_addr = byte_acc ? in_chan.byte_value : scan_byte;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (req)
            REQ_SUMMARY: state_nxt = ST_SUM;
            REQ_NEXT:    state_nxt = ST_SCAN;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_DONE;
        end else if (scan_hit) begin
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        if (scan_end || scan_hit) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SUM, ST_EMIT, ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    res_valid          = 1'b0;
    res                = '0;
    res.total_chars    = to_out(total_r);
    res.unique_chars   = distinct_r;
    case (state_r)
      ST_SUM: begin
        res_valid       = 1'b1;
        res.result_kind = RES_SUMMARY;
      end
      ST_EMIT: begin
        res_valid          = 1'b1;
        res.result_kind    = RES_ENTRY;
        res.char_code      = rank_to_byte(found_r);
        res.char_count     = to_out(cnt_rd_data);
        res.first_position = to_out(pos_rd_data);
        res.is_last        = last_r;
      end
      ST_DONE: begin
        res_valid       = 1'b1;
        res.result_kind = RES_DONE;
      end
      default: res_valid = 1'b0;
    endcase
  end

  always_comb begin
    present_nxt  = present_r;
    total_nxt    = total_r;
    distinct_nxt = distinct_r;
    cursor_nxt   = cursor_r;
    if (s1_vld_r) begin
      present_nxt[s1_addr_r] = 1'b1;
      if (total_r != CNT_MAX) begin
        total_nxt = total_r + 1'b1;
      end
      if (!s1_present) begin
        distinct_nxt = distinct_r + 1'b1;
      end
    end
    // clear wins over a byte finishing in the same cycle
    if (in_acc && (req == REQ_CLEAR)) begin
      present_nxt  = '0;
      total_nxt    = '0;
      distinct_nxt = '0;
      cursor_nxt   = '0;
    end
    if (res_ready) begin
      case (state_r)
        ST_SUM:  cursor_nxt = '0;
        ST_EMIT: cursor_nxt = found_r + 1'b1;
        ST_DONE: cursor_nxt = RANK_W'(NUM_VALUES);
        default: cursor_nxt = cursor_nxt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      s1_vld_r   <= 1'b0;
      present_r  <= '0;
      total_r    <= '0;
      distinct_r <= '0;
      cursor_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      s1_vld_r   <= byte_acc;
      present_r  <= present_nxt;
      total_r    <= total_nxt;
      distinct_r <= distinct_nxt;
      cursor_r   <= cursor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_acc) begin
      s1_addr_r <= in_chan.byte_value;
      fwd_hit_r <= s1_vld_r && (s1_addr_r == in_chan.byte_value);
      fwd_val_r <= s1_cnt;
    end
    if (in_acc && (req == REQ_NEXT)) begin
      scan_r <= cursor_r;
    end else if (((state_r == ST_SCAN) && !scan_end) ||
                 ((state_r == ST_LAST) && !scan_end && !scan_hit)) begin
      scan_r <= scan_r + 1'b1;
    end
    if ((state_r == ST_SCAN) && scan_hit) begin
      found_r <= scan_r;
    end
    if ((state_r == ST_LAST) && (scan_end || scan_hit)) begin
      last_r <= scan_end;
    end
  end

  a_distinct_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
    distinct_r == UNIQ_W'($countones(present_r)))
    else $error("distinct count out of step with present map");

  a_update_only_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> $past(state_r == ST_IDLE))
    else $error("byte update in flight outside idle");

  a_listed_entry_present: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> present_r[rank_to_byte(found_r)])
    else $error("listed entry is not present");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= RANK_W'(NUM_VALUES))
    else $error("list cursor beyond end");

endmodule

// ===== hw/rtl/bfh_out_reg.sv =====
`timescale 1ns / 1ps

module bfh_out_reg import bfh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       res_valid,
  input  result_t    res,
  output logic       res_ready,
  bfh_out_if.source  out_chan
);

  logic    valid_r, valid_nxt;
  result_t data_r;
  logic    load;

  assign res_ready = !valid_r || out_chan.ready;
  assign load      = res_valid && res_ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_chan.valid          = valid_r;
  assign out_chan.result_kind    = data_r.result_kind;
  assign out_chan.char_code      = data_r.char_code;
  assign out_chan.char_count     = data_r.char_count;
  assign out_chan.first_position = data_r.first_position;
  assign out_chan.total_chars    = data_r.total_chars;
  assign out_chan.unique_chars   = data_r.unique_chars;
  assign out_chan.is_last        = data_r.is_last;

endmodule
